@@ design/assert_macros.svh @@
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define JVCS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, held off during reset.
`define JVCS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ design/jvcs_pkg.sv @@
// ----------------------------------------------------------------------------
// jvcs_pkg
// Shared constants and types for the jittered Voronoi corner selector.
// ----------------------------------------------------------------------------
package jvcs_pkg;

    localparam logic [63:0] LCG_MUL = 64'd6364136223846793005;
    localparam logic [63:0] LCG_ADD = 64'd1442695040888963407;

    localparam int NUM_AXES    = 3;
    localparam int NUM_CORNERS = 8;
    localparam int NUM_STEPS   = 8;
    localparam int LCG_LAT     = 4;
    localparam int DIST_LAT    = 3;
    localparam int TREE_LAT    = 3;
    localparam int PIPE_LAT    = 1 + NUM_STEPS * LCG_LAT + DIST_LAT + TREE_LAT;

    // hash steps whose result carries a jitter code
    localparam logic [2:0] STEP_JIT_X = 3'd5;
    localparam logic [2:0] STEP_JIT_Y = 3'd6;
    localparam logic [2:0] STEP_JIT_Z = 3'd7;

    typedef logic signed [29:0] t_cell;
    typedef logic [9:0]         t_jit;
    typedef logic [27:0]        t_sq;
    typedef logic [29:0]        t_dist;

    // per-corner request context handed along the hash chain
    typedef struct packed {
        logic [63:0]     seed;
        t_cell [2:0]     cc;
        logic [2:0][1:0] q;
        t_jit [2:0]      k;
    } t_ctx;

endpackage

@@ design/jittered_voronoi_corner_select_top.sv @@
// ----------------------------------------------------------------------------
// jittered_voronoi_corner_select_top
// Nearest jittered corner of a 3D grid cell, one request per cycle unless stalled.
// ----------------------------------------------------------------------------
// channel  direction  valid    stall    payload
// request  in         i_valid  o_stall  i_seed_value, i_pos_x, i_pos_y, i_pos_z
// result   out        o_valid  i_stall  o_corner_index
//
// One request enters per cycle while not frozen; the path is an input stage,
// eight hash cells of four stages each per corner lane, three distance stages
// and a three-level registered minimum tree ending in the output register.
// Reset clears only the valid pipeline. The whole pipeline freezes while a
// result waits and i_stall is high; o_stall follows that condition.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jittered_voronoi_corner_select_top import jvcs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [63:0]         i_seed_value,
    input  logic signed [30:0]  i_pos_x,
    input  logic signed [30:0]  i_pos_y,
    input  logic signed [30:0]  i_pos_z,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0]          o_corner_index
);

    logic                w_en;
    logic [PIPE_LAT-1:0] r_vld;
    t_ctx                r_in;
    t_ctx                n_in;
    logic signed [31:0]  w_a [NUM_AXES];

    logic [63:0] w_r   [NUM_CORNERS][NUM_STEPS+1];
    t_ctx        w_ctx [NUM_CORNERS][NUM_STEPS+1];
    t_dist       w_dist [NUM_CORNERS];

    t_dist      r_l1_d [4];
    logic [2:0] r_l1_i [4];
    t_dist      r_l2_d [2];
    logic [2:0] r_l2_i [2];
    logic [2:0] r_l3_i;

    // advance unless a finished result is held back
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[PIPE_LAT-1];

    // split (p-2) into floor cell and quarter fraction
    always_comb begin
        w_a[0] = {i_pos_x[30], i_pos_x} - 32'sd2;
        w_a[1] = {i_pos_y[30], i_pos_y} - 32'sd2;
        w_a[2] = {i_pos_z[30], i_pos_z} - 32'sd2;
        n_in      = '0;
        n_in.seed = i_seed_value;
        for (int a = 0; a < NUM_AXES; a++) begin
            n_in.cc[a] = w_a[a][31:2];
            n_in.q[a]  = w_a[a][1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in <= n_in;
        end
    end

    // shift valid flags alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_valid};
        end
    end

    // one lane per corner: chain of hash cells, then distance
    for (genvar j = 0; j < NUM_CORNERS; j++) begin : g_lane
        always_comb begin
            w_ctx[j][0] = r_in;
            for (int a = 0; a < NUM_AXES; a++) begin
                w_ctx[j][0].cc[a] = r_in.cc[a] + t_cell'((j >> (2 - a)) & 1);
            end
            w_r[j][0] = r_in.seed;
        end

        for (genvar s = 0; s < NUM_STEPS; s++) begin : g_step
            jvcs_lcg_cell u_cell (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_step (3'(s)),
                .i_s    (w_r[j][s]),
                .i_ctx  (w_ctx[j][s]),
                .o_r    (w_r[j][s+1]),
                .o_ctx  (w_ctx[j][s+1])
            );
        end

        jvcs_dist_unit u_dist (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_corner (3'(j)),
            .i_ctx    (w_ctx[j][NUM_STEPS]),
            .o_dist   (w_dist[j])
        );
    end

    // minimum tree; right side wins only when strictly nearer
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int m = 0; m < 4; m++) begin
                if (w_dist[2*m+1] < w_dist[2*m]) begin
                    r_l1_d[m] <= w_dist[2*m+1];
                    r_l1_i[m] <= 3'(2*m+1);
                end else begin
                    r_l1_d[m] <= w_dist[2*m];
                    r_l1_i[m] <= 3'(2*m);
                end
            end
            for (int m = 0; m < 2; m++) begin
                if (r_l1_d[2*m+1] < r_l1_d[2*m]) begin
                    r_l2_d[m] <= r_l1_d[2*m+1];
                    r_l2_i[m] <= r_l1_i[2*m+1];
                end else begin
                    r_l2_d[m] <= r_l1_d[2*m];
                    r_l2_i[m] <= r_l1_i[2*m];
                end
            end
            r_l3_i <= (r_l2_d[1] < r_l2_d[0]) ? r_l2_i[1] : r_l2_i[0];
        end
    end

    assign o_corner_index = r_l3_i;

    `JVCS_ASSERT_NXT(a_accept_enters, i_clk, i_rst_n, i_valid && !o_stall, r_vld[0])
    `JVCS_ASSERT_NXT(a_held_result, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `JVCS_ASSERT_IMP(a_free_when_empty, i_clk, i_rst_n, !o_valid, !o_stall)

endmodule

@@ design/jvcs_lcg_cell.sv @@
// ----------------------------------------------------------------------------
// jvcs_lcg_cell
// One quadratic LCG step s*(s*M+A)+c, four stages of 32-bit partial products.
// ----------------------------------------------------------------------------
module jvcs_lcg_cell import jvcs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [2:0]  i_step,
    input  logic [63:0] i_s,
    input  t_ctx        i_ctx,
    output logic [63:0] o_r,
    output t_ctx        o_ctx
);

    logic [63:0] r_p0, r_s0, r_t, r_s1, r_q0, r_c2, r_r;
    logic [31:0] r_p1, r_p2, r_q1, r_q2;
    t_ctx        r_ctx0, r_ctx1, r_ctx2, r_ctx3;
    logic [63:0] n_p0, n_t, n_q0, n_c2, n_r;
    logic [31:0] n_p1, n_p2, n_q1, n_q2;
    t_ctx        n_ctx3;

    // stage 0: partial products of s by the multiplier
    always_comb begin
        n_p0 = 64'(i_s[31:0]) * 64'(LCG_MUL[31:0]);
        n_p1 = i_s[63:32] * LCG_MUL[31:0];
        n_p2 = i_s[31:0] * LCG_MUL[63:32];
    end

    // stage 1: fold into t = s*M + A
    always_comb begin
        n_t = r_p0 + {r_p1 + r_p2, 32'b0} + LCG_ADD;
    end

    // stage 2: partial products of s by t, pick the addend
    always_comb begin
        n_q0 = 64'(r_s1[31:0]) * 64'(r_t[31:0]);
        n_q1 = r_s1[63:32] * r_t[31:0];
        n_q2 = r_s1[31:0] * r_t[63:32];
        case (i_step)
            3'd0, 3'd3: n_c2 = {{34{r_ctx1.cc[0][29]}}, r_ctx1.cc[0]};
            3'd1, 3'd4: n_c2 = {{34{r_ctx1.cc[1][29]}}, r_ctx1.cc[1]};
            3'd2, STEP_JIT_X: n_c2 = {{34{r_ctx1.cc[2][29]}}, r_ctx1.cc[2]};
            default: n_c2 = r_ctx1.seed;
        endcase
    end

    // stage 3: final sum, latch jitter code where this step supplies one
    always_comb begin
        n_r    = r_q0 + {r_q1 + r_q2, 32'b0} + r_c2;
        n_ctx3 = r_ctx2;
        case (i_step)
            STEP_JIT_X: n_ctx3.k[0] = n_r[33:24];
            STEP_JIT_Y: n_ctx3.k[1] = n_r[33:24];
            STEP_JIT_Z: n_ctx3.k[2] = n_r[33:24];
            default: ;
        endcase
    end

    // advance all stages together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0   <= n_p0;
            r_p1   <= n_p1;
            r_p2   <= n_p2;
            r_s0   <= i_s;
            r_ctx0 <= i_ctx;
            r_t    <= n_t;
            r_s1   <= r_s0;
            r_ctx1 <= r_ctx0;
            r_q0   <= n_q0;
            r_q1   <= n_q1;
            r_q2   <= n_q2;
            r_c2   <= n_c2;
            r_ctx2 <= r_ctx1;
            r_r    <= n_r;
            r_ctx3 <= n_ctx3;
        end
    end

    assign o_r   = r_r;
    assign o_ctx = r_ctx3;

endmodule

@@ design/jvcs_dist_unit.sv @@
// ----------------------------------------------------------------------------
// jvcs_dist_unit
// Squared distance of one jittered corner, in units of (1/10240 cell)^2, three stages.
// ----------------------------------------------------------------------------
module jvcs_dist_unit import jvcs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_en,
    input  logic [2:0] i_corner,
    input  t_ctx       i_ctx,
    output t_dist      o_dist
);

    logic signed [15:0] r_off [NUM_AXES];
    t_sq                r_sq  [NUM_AXES];
    t_dist              r_dist;
    logic signed [15:0] n_off [NUM_AXES];
    logic signed [15:0] w_qs  [NUM_AXES];
    logic signed [31:0] n_sq  [NUM_AXES];

    // axis offset 2560*q' + 9*(k-512) and its square
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            w_qs[a]  = $signed({14'b0, i_ctx.q[a]})
                     - (i_corner[2-a] ? 16'sd4 : 16'sd0);
            n_off[a] = w_qs[a] * 16'sd2560
                     + 16'sd9 * ($signed({6'b0, i_ctx.k[a]}) - 16'sd512);
            n_sq[a]  = r_off[a] * r_off[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_off[a] <= n_off[a];
                r_sq[a]  <= n_sq[a][27:0];
            end
            r_dist <= {2'b0, r_sq[0]} + {2'b0, r_sq[1]} + {2'b0, r_sq[2]};
        end
    end

    assign o_dist = r_dist;

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the jittered Voronoi corner selector: random and
// corner-case requests with random gaps and stalls, checked in order against
// a behavioral nearest-corner predictor.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jvcs_pkg::*;

    typedef struct {
        logic [63:0]        seed;
        logic signed [30:0] px;
        logic signed [30:0] py;
        logic signed [30:0] pz;
    } t_query;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [63:0]        i_seed_value = '0;
    logic signed [30:0] i_pos_x = '0;
    logic signed [30:0] i_pos_y = '0;
    logic signed [30:0] i_pos_z = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [2:0]         o_corner_index;

    t_query     pending_q[$];
    logic [2:0] nearest_q[$];
    int         err_count = 0;
    int         sent_count = 0;
    int         got_count = 0;
    int         gap_left = 0;
    int         hold_left = 0;
    int         long_hold = 0;
    bit         stim_done = 0;
    t_query     cur_req;
    logic       o_stall_s = 1'b0;

    jittered_voronoi_corner_select_top uut (.*);

    always #1 i_clk = ~i_clk;

    // Advance the quadratic LCG hash one step
    function automatic logic [63:0] hash_step(logic [63:0] s, logic [63:0] c);
        return s * (s * 64'd6364136223846793005 + 64'd1442695040888963407) + c;
    endfunction

    function automatic longint jitter_of(logic [63:0] r);
        longint k;
        k = longint'(r[33:24]);
        return 9 * (k - 512);
    endfunction

    // Nearest jittered corner of the cell around the point
    function automatic logic [2:0] nearest_corner(t_query q);
        longint cell_at[3], frac[3], off[3], a;
        logic [63:0] cc[3], r;
        longint unsigned dist_sq, best;
        logic [2:0] best_i;
        logic signed [30:0] p[3];
        best = 0;
        best_i = 0;
        p[0] = q.px; p[1] = q.py; p[2] = q.pz;
        for (int ax = 0; ax < 3; ax++) begin
            a = longint'(p[ax]) - 2;
            frac[ax] = a & 3;
            cell_at[ax] = (a - frac[ax]) / 4;
        end
        for (int i = 0; i < 8; i++) begin
            for (int ax = 0; ax < 3; ax++) begin
                int hi;
                hi = (i >> (2 - ax)) & 1;
                cc[ax] = cell_at[ax] + hi;
                off[ax] = 2560 * (frac[ax] - (hi ? 4 : 0));
            end
            r = hash_step(q.seed, cc[0]);
            r = hash_step(r, cc[1]);
            r = hash_step(r, cc[2]);
            r = hash_step(r, cc[0]);
            r = hash_step(r, cc[1]);
            r = hash_step(r, cc[2]);
            off[0] += jitter_of(r);
            r = hash_step(r, q.seed);
            off[1] += jitter_of(r);
            r = hash_step(r, q.seed);
            off[2] += jitter_of(r);
            dist_sq = off[0] * off[0] + off[1] * off[1] + off[2] * off[2];
            if (i == 0 || dist_sq < best) begin
                best = dist_sq;
                best_i = 3'(i);
            end
        end
        return best_i;
    endfunction

    function automatic logic signed [30:0] rand_pos();
        case ($urandom_range(0, 3))
            0: return 31'($urandom);
            1: return 31'(int'($urandom_range(0, 40)) - 20);
            2: return $urandom_range(0, 1) ? 31'h3FFF_FFFF - 31'($urandom_range(0, 7))
                                           : 31'h4000_0000 + 31'($urandom_range(0, 7));
            default: return 31'(int'($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    function automatic logic [63:0] rand_seed();
        case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Fill the request queue: directed extremes, small directed positions, then random
    initial begin
        t_query q;
        logic signed [30:0] edges[6];
        edges = '{31'h4000_0000, 31'h3FFF_FFFF, 31'sd0, -31'sd1, 31'sd2, 31'sd1};
        for (int i = 0; i < 6; i++) begin
            q.seed = (i % 2) ? '1 : 64'd0;
            q.px = edges[i]; q.py = edges[(i + 2) % 6]; q.pz = edges[(i + 4) % 6];
            pending_q = {pending_q, q};
        end
        for (int i = 0; i < 12; i++) begin
            q.seed = (i < 4) ? 64'h8000_0000_0000_0001 : {$urandom, $urandom};
            q.px = 31'(i); q.py = -31'(i); q.pz = 31'(i * 3);
            pending_q = {pending_q, q};
        end
        for (int i = 0; i < 950; i++) begin
            q.seed = rand_seed();
            q.px = rand_pos(); q.py = rand_pos(); q.pz = rand_pos();
            pending_q = {pending_q, q};
        end
    end

    // Drive requests at the falling edge with random gaps
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall_s) begin
                nearest_q = {nearest_q, nearest_corner(cur_req)};
                sent_count++;
            end
            if (!(i_valid && o_stall_s)) begin
                if (gap_left > 0 || pending_q.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    i_valid <= 1'b0;
                    if (pending_q.size() == 0 && !(i_valid && o_stall_s)) stim_done = 1;
                end else begin
                    cur_req = pending_q.pop_front();
                    i_seed_value <= cur_req.seed;
                    i_pos_x <= cur_req.px;
                    i_pos_y <= cur_req.py;
                    i_pos_z <= cur_req.pz;
                    i_valid <= 1'b1;
                    gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 0;
                end
            end
        end
    end

    // Sample the input handshake at the rising edge
    always @(posedge i_clk) begin
        o_stall_s <= o_stall;
    end

    // Receiver stall: random holds plus one long hold-off
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (sent_count == 300 && long_hold == 0) begin
                long_hold = 1;
                hold_left = 120;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (($urandom_range(0, 3) == 0) && sent_count > 40) begin
                hold_left = $urandom_range(0, 4);
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Check results at the rising edge
    always @(posedge i_clk) begin
        logic [2:0] exp_i;
        if (i_rst_n && o_valid && !i_stall) begin
            got_count++;
            if (nearest_q.size() == 0) begin
                $error("corner_index: unexpected result %0d", o_corner_index);
                err_count++;
            end else begin
                exp_i = nearest_q.pop_front();
                if (o_corner_index !== exp_i) begin
                    $error("corner_index: expected %0d, actual %0d", exp_i, o_corner_index);
                    err_count++;
                end
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done);
        wait (nearest_q.size() == 0);
        repeat (3 * PIPE_LAT) @(posedge i_clk);
        $display("Covered %0d requests and %0d checked corner results,", sent_count, got_count);
        $display("including field extremes, random gaps and a long output hold-off.");
        if (err_count == 0 && nearest_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+design
design/jvcs_pkg.sv
design/jvcs_lcg_cell.sv
design/jvcs_dist_unit.sv
design/jittered_voronoi_corner_select_top.sv
bench/tb.sv
